/* hw/rtl/sha1as_pkg.sv */
`timescale 1ns / 1ps
package sha1as_pkg;

	localparam int POS_W = 48;

	localparam logic [1:0] OP_DATA   = 2'd0;
	localparam logic [1:0] OP_FINISH = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_SPARE  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OOO      = 3'd1;
	localparam logic [2:0] ST_DIGEST   = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_MISMATCH = 3'd4;
	localparam logic [2:0] ST_INACTIVE = 3'd5;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int LEN_SHIFT = 3;

	localparam logic [31:0] SHA_IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef enum logic [1:0] {
		PH_INACTIVE = 2'd0,
		PH_HASHING  = 2'd1,
		PH_DONE     = 2'd2,
		PH_SPARE    = 2'd3
	} phase_t;

	typedef enum logic [4:0] {
		SQ_IDLE  = 5'b00001,
		SQ_LOAD  = 5'b00010,
		SQ_ROUND = 5'b00100,
		SQ_ADD   = 5'b01000,
		SQ_EMIT  = 5'b10000
	} seq_t;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [63:0]      data_word;
		logic [POS_W-1:0] position;
		logic [3:0]       valid_bytes;
		logic [POS_W-1:0] total_size;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] digest_word;
		logic        last;
	} out_beat_t;

endpackage

/* hw/rtl/sha1_append_stream_hasher_unit.sv */
`timescale 1ns / 1ps
// Data, clear and error beats put their result in the output register in the cycle after
// acceptance. A word that fills a 64-byte block then holds the input through the load, the
// SHA-1 rounds on the single round unit and the chain add. Finish runs one or two blocks
// and then five digest beats. The input stalls while a block is compressed or digest beats
// are sent. Async reset (arst_n low) loads the IV, clears fill and committed offset, sets
// hashing on; the block buffer is not reset.
module sha1_append_stream_hasher_unit
	import sha1as_pkg::*;
#(
	parameter int OFFSET_BITS = 48
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_beat,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_beat,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_enable
);

	// control state
	seq_t                   seq_q;
	phase_t                 phase_q;
	logic                   enable_q;
	logic [31:0]            chain_q [5];
	logic [6:0]             fill_q;
	logic [OFFSET_BITS-1:0] committed_q;
	logic [6:0]             rnd_q;
	logic                   blk_q;
	logic                   fin_q;
	logic                   n2_q;
	logic [6:0]             tail_q;
	logic [63:0]            len_q;
	logic [2:0]             emit_q;
	logic                   out_valid_q;
	out_beat_t              out_q;

	// datapath (no reset)
	logic [63:0] buf_q [8];
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;

	logic                   in_take, out_free, out_set, fin_go;
	logic [OFFSET_BITS-1:0] pos_o, size_o, end_o;
	logic [63:0]            pos64, size64;
	logic [3:0]             vb_eff;
	logic                   in_order, data_restart, data_ok;
	logic [2:0]             data_st;
	logic [6:0]             fill_base, fill_new;
	logic [31:0]            bufw, msgw, sched, wt, f, k, t;

	// Builds one message word: buffer bytes, then on the final pass the pad mark,
	// zeros and the big-endian bit length at the end of the last block.
	function automatic logic [31:0] msg_word(input logic [31:0] bw, input logic [6:0] base,
			input logic fin, input logic [6:0] tail, input logic n2, input logic [63:0] len);
		logic [31:0] res;
		logic [7:0]  bi, lim, bb;
		logic [2:0]  li;
		res = '0;
		for (int j = 0; j < 4; j++) begin
			bi = {1'b0, base} + 8'(j);
			bb = bw[31 - 8*j -: 8];
			lim = n2 ? 8'd128 : 8'd64;
			li = 3'(lim - 8'd1 - bi);
			if (!fin || bi < {1'b0, tail}) begin
				res[31 - 8*j -: 8] = bb;
			end else if (bi == {1'b0, tail}) begin
				res[31 - 8*j -: 8] = PAD_MARK;
			end else if (bi >= lim - 8'd8 && bi < lim) begin
				res[31 - 8*j -: 8] = len[8*li +: 8];
			end else begin
				res[31 - 8*j -: 8] = 8'h00;
			end
		end
		return res;
	endfunction

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !(seq_q == SQ_IDLE && out_free);
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	// offsets live modulo 2^OFFSET_BITS
	assign pos64  = 64'(in_beat.position);
	assign size64 = 64'(in_beat.total_size);
	assign pos_o  = pos64[OFFSET_BITS-1:0];
	assign size_o = size64[OFFSET_BITS-1:0];
	assign end_o  = committed_q + OFFSET_BITS'(fill_q);

	assign vb_eff       = (in_beat.valid_bytes > 4'd8) ? 4'd8 : in_beat.valid_bytes;
	assign in_order     = phase_q == PH_HASHING && fill_q[2:0] == 3'd0 && pos_o == end_o;
	assign data_restart = !in_order && pos_o == '0 && enable_q;
	assign data_ok      = in_order || data_restart;
	assign fill_base    = data_restart ? 7'd0 : fill_q;
	assign fill_new     = fill_base + {3'b000, vb_eff};

	// data beat status: zero-byte and accepted words are OK
	assign data_st = (in_beat.valid_bytes == 4'd0 || data_ok) ? ST_OK
		: ((phase_q == PH_HASHING || phase_q == PH_DONE) ? ST_OOO : ST_INACTIVE);

	// finish that goes on to padding and compression
	assign fin_go = phase_q == PH_HASHING && size_o != '0 && size_o == end_o;

	// output register loads a new beat this cycle
	assign out_set = (seq_q == SQ_EMIT && out_free)
		|| (seq_q == SQ_IDLE && in_take && (in_beat.opcode inside {OP_DATA, OP_CLEAR}
		|| (in_beat.opcode == OP_FINISH && phase_q != PH_DONE && !fin_go)));

	// round unit: schedule word, round function, new A
	assign bufw  = rnd_q[0] ? buf_q[rnd_q[3:1]][31:0] : buf_q[rnd_q[3:1]][63:32];
	assign msgw  = msg_word(bufw, {blk_q, rnd_q[3:0], 2'b00}, fin_q, tail_q, n2_q, len_q);
	assign sched = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign wt    = (rnd_q < 7'd16) ? msgw : {sched[30:0], sched[31]};

	always_comb begin
		if (rnd_q inside {[7'd0:7'd19]}) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5A827999;
		end else if (rnd_q inside {[7'd20:7'd39]}) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ED9EBA1;
		end else if (rnd_q inside {[7'd40:7'd59]}) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hCA62C1D6;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SQ_IDLE;
			phase_q     <= PH_HASHING;
			enable_q    <= 1'b1;
			for (int i = 0; i < 5; i++) chain_q[i] <= SHA_IV[i];
			fill_q      <= '0;
			committed_q <= '0;
			rnd_q       <= '0;
			blk_q       <= 1'b0;
			fin_q       <= 1'b0;
			n2_q        <= 1'b0;
			tail_q      <= '0;
			len_q       <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) enable_q <= cfg_enable;
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (seq_q)
				SQ_IDLE: begin
					if (in_take) begin
						case (in_beat.opcode)
							OP_DATA: begin
								out_q <= '{status: data_st, digest_word: '0, last: 1'b1};
								if (in_beat.valid_bytes != 4'd0) begin
									if (data_ok) begin
										if (data_restart) begin
											for (int i = 0; i < 5; i++) chain_q[i] <= SHA_IV[i];
											committed_q <= '0;
											phase_q     <= PH_HASHING;
										end
										fill_q <= fill_new;
										if (fill_new >= 7'd64) begin
											fin_q <= 1'b0;
											blk_q <= 1'b0;
											seq_q <= SQ_LOAD;
										end
									end else begin
										phase_q <= PH_INACTIVE;
									end
								end
							end
							OP_FINISH: begin
								if (phase_q == PH_DONE) begin
									emit_q <= '0;
									seq_q  <= SQ_EMIT;
								end else if (fin_go) begin
									fin_q  <= 1'b1;
									blk_q  <= 1'b0;
									tail_q <= fill_q;
									n2_q   <= fill_q >= 7'd56;
									len_q  <= 64'(size_o) << LEN_SHIFT;
									seq_q  <= SQ_LOAD;
								end else begin
									// error: report, then restart
									if (phase_q != PH_HASHING) begin
										out_q <= '{status: ST_INACTIVE, digest_word: '0, last: 1'b1};
									end else if (size_o == '0) begin
										out_q <= '{status: ST_EMPTY, digest_word: '0, last: 1'b1};
									end else begin
										out_q <= '{status: ST_MISMATCH, digest_word: '0, last: 1'b1};
									end
									for (int i = 0; i < 5; i++) chain_q[i] <= SHA_IV[i];
									fill_q      <= '0;
									committed_q <= '0;
									phase_q     <= enable_q ? PH_HASHING : PH_INACTIVE;
								end
							end
							OP_CLEAR: begin
								out_q <= '{status: enable_q ? ST_OK : ST_INACTIVE,
									digest_word: '0, last: 1'b1};
								for (int i = 0; i < 5; i++) chain_q[i] <= SHA_IV[i];
								fill_q      <= '0;
								committed_q <= '0;
								phase_q     <= enable_q ? PH_HASHING : PH_INACTIVE;
							end
							default: begin
							end
						endcase
					end
				end
				SQ_LOAD: begin
					rnd_q <= '0;
					seq_q <= SQ_ROUND;
				end
				SQ_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) seq_q <= SQ_ADD;
				end
				SQ_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					if (fin_q && n2_q && !blk_q) begin
						blk_q <= 1'b1;
						seq_q <= SQ_LOAD;
					end else if (fin_q) begin
						phase_q <= PH_DONE;
						fill_q  <= '0;
						emit_q  <= '0;
						seq_q   <= SQ_EMIT;
					end else begin
						committed_q <= committed_q + OFFSET_BITS'(64);
						fill_q      <= '0;
						seq_q       <= SQ_IDLE;
					end
				end
				SQ_EMIT: begin
					if (out_free) begin
						out_q <= '{status: ST_DIGEST, digest_word: chain_q[emit_q],
							last: emit_q == 3'd4};
						if (emit_q == 3'd4) begin
							seq_q <= SQ_IDLE;
						end else begin
							emit_q <= emit_q + 3'd1;
						end
					end
				end
				default: seq_q <= SQ_IDLE;
			endcase
		end
	end

	// block buffer write and round datapath
	always_ff @(posedge clk) begin
		if (seq_q == SQ_IDLE && in_take && in_beat.opcode == OP_DATA
				&& in_beat.valid_bytes != 4'd0 && data_ok) begin
			buf_q[fill_base[5:3]] <= in_beat.data_word;
		end
		if (seq_q == SQ_LOAD) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (seq_q == SQ_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wt;
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t;
		end
	end

endmodule
